// ===== rtl/spwm_pkg.sv =====
// ---------------------------------------------------------------------------
// spwm_pkg: shared constants of the servo pulse width mapper
// Register indexes, field widths and the reciprocal used to divide by one
// hundred.
// ---------------------------------------------------------------------------
package spwm_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_ADDR_W-1:0] REG_ACT_LIMIT         = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TRIM_PERCENT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIM_PERCENT      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERSE_DIRECTION = 2'd3;

  localparam int LIM_W    = 15;
  localparam int MTP_W    = 7;
  localparam int TP_W     = 8;
  localparam int ACT_W    = 16;
  localparam int PW_OUT_W = 11;

  localparam int PCT = 100;

  // x / 100 == (x * RECIP_M) >> RECIP_SHIFT for every x below 2^17.
  localparam int                RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_M     = 18'd167773;
  localparam int                RECIP_SHIFT = 24;

endpackage

// ===== rtl/servo_pulse_width_mapper_top.sv =====
// ---------------------------------------------------------------------------
// servo_pulse_width_mapper_top: actuation accumulator and servo pulse mapper
// Accumulates signed actuation beats and maps the clamped, trimmed value to
// a servo pulse width with a bit-serial divider.
// ---------------------------------------------------------------------------
// Usage:
// An input beat carries add_value in in_tdata and mode in in_tuser. Mode 0
// adds add_value to the 16-bit accumulator, which wraps; mode 1 clears it.
// Every input beat gives exactly one output beat with pulse_width and the
// unclamped accumulator value.
// The user must write the four registers through cfg_we, cfg_addr and
// cfg_wdata while the block is idle; the block itself does not enforce
// this. A write takes effect with the next input beat. The numerator is
// NUM_W = 15 + clog2(2*HALF_SPAN+1) bits wide, 25 at the default
// parameters. States T1 to T4 form the trim through the reciprocal
// multiplier, MAP forms the numerator, and the restoring divider by the
// actuation limit takes one quotient bit per cycle. One beat is in work at
// a time, so a new beat is taken only after the previous one has finished.
// The output register holds a finished beat while the receiver stalls; the
// next input beat is still taken and worked on, and the block waits only
// when a second result is ready before the first has been taken.
// Reset clears the accumulator, restores the register defaults and drops
// out_tvalid.
// ---------------------------------------------------------------------------
module servo_pulse_width_mapper_top
  import spwm_pkg::*;
#(
  parameter int CENTER_WIDTH = 1500,
  parameter int HALF_SPAN    = 500
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] add_value
  input  logic [0:0]            in_tuser,   // [0] mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [10:0] pulse_width, [26:11] actuation
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int P1_W  = $clog2(HALF_SPAN * PCT + 1);
  localparam int TM_W  = $clog2(HALF_SPAN + 1);
  localparam int FAC_W = $clog2(2 * HALF_SPAN + 1);
  localparam int NUM_W = LIM_W + FAC_W;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int PW_W  = $clog2(CENTER_WIDTH + 2 * HALF_SPAN + 1) + 1;

  localparam logic signed [PW_W-1:0] CENTER_S = PW_W'(CENTER_WIDTH);
  localparam logic signed [PW_W-1:0] HS_S     = PW_W'(HALF_SPAN);
  localparam logic signed [PW_W-1:0] LO_S     = PW_W'(CENTER_WIDTH - HALF_SPAN);
  localparam logic signed [PW_W-1:0] HI_S     = PW_W'(CENTER_WIDTH + HALF_SPAN);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_T1   = 8'b0000_0010,
    ST_T2   = 8'b0000_0100,
    ST_T3   = 8'b0000_1000,
    ST_T4   = 8'b0001_0000,
    ST_MAP  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [LIM_W-1:0]       cl_r;
  logic [MTP_W-1:0]       mtp_r;
  logic signed [TP_W-1:0] tp_r;
  logic                   inv_r;
  logic [ACT_W-1:0]       acc_r;

  logic [P1_W-1:0]        p_r;
  logic [TM_W-1:0]        tm_r;
  logic signed [TM_W:0]   trim_r;
  logic signed [LIM_W+1:0] a_r;
  logic signed [PW_W-1:0] base_r;
  logic [NUM_W-1:0]       dq_r;
  logic [LIM_W:0]         rem_r;
  logic [CNT_W-1:0]       cnt_r;

  logic                   out_valid_r;
  logic [PW_OUT_W-1:0]    out_pw_r;
  logic [ACT_W-1:0]       out_act_r;

  logic                   in_fire;
  logic                   out_free;
  logic [LIM_W-1:0]       lim_eff;
  logic [MTP_W-1:0]       mtp_eff;
  logic [TP_W-1:0]        tp_abs;
  logic [MTP_W-1:0]       tp_mag;
  logic [P1_W+RECIP_W-1:0] rprod;
  logic [TM_W+MTP_W-1:0]  prod3;
  logic [TM_W-1:0]        tm2;
  logic signed [LIM_W+1:0] lim_s;
  logic signed [LIM_W+1:0] a_ext;
  logic signed [LIM_W+1:0] a_cl;
  logic signed [LIM_W+1:0] a_sum;
  logic signed [PW_W-1:0] trim_w;
  logic signed [PW_W-1:0] fac_s;
  logic [LIM_W-1:0]       mul_op;
  logic [FAC_W-1:0]       fac_op;
  logic [NUM_W-1:0]       num;
  logic [LIM_W:0]         rem_sh;
  logic [LIM_W+1:0]       rem_diff;
  logic signed [PW_W-1:0] pw_sum;
  logic signed [PW_W-1:0] pw_cl;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_act_r, out_pw_r};

  assign lim_eff = (cl_r == '0) ? LIM_W'(1) : cl_r;
  assign mtp_eff = (int'(mtp_r) > PCT) ? MTP_W'(PCT) : mtp_r;
  assign tp_abs  = tp_r[TP_W-1] ? (TP_W'(0) - tp_r) : tp_r;
  assign tp_mag  = (int'(tp_abs) > PCT) ? MTP_W'(PCT) : tp_abs[MTP_W-1:0];

  assign rprod = {{RECIP_W{1'b0}}, p_r} * {{P1_W{1'b0}}, RECIP_M};
  assign tm2   = rprod[RECIP_SHIFT +: TM_W];
  assign prod3 = {{MTP_W{1'b0}}, tm_r} * {{TM_W{1'b0}}, tp_mag};

  assign lim_s = $signed({2'b00, lim_eff});
  assign a_ext = $signed({acc_r[ACT_W-1], acc_r});

  always_comb begin
    if (a_ext > lim_s) begin
      a_cl = lim_s;
    end else if (a_ext < -lim_s) begin
      a_cl = -lim_s;
    end else begin
      a_cl = a_ext;
    end
  end

  assign a_sum  = a_r + lim_s;
  assign trim_w = PW_W'(trim_r);
  assign fac_s  = a_r[LIM_W+1] ? (HS_S + trim_w) : (HS_S - trim_w);
  assign mul_op = a_r[LIM_W+1] ? a_sum[LIM_W-1:0] : a_r[LIM_W-1:0];
  assign fac_op = fac_s[FAC_W-1:0];
  assign num    = {{FAC_W{1'b0}}, mul_op} * {{LIM_W{1'b0}}, fac_op};

  assign rem_sh   = {rem_r[LIM_W-1:0], dq_r[NUM_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, lim_eff};

  assign pw_sum = base_r + PW_W'($signed({1'b0, dq_r[FAC_W-1:0]}));

  always_comb begin
    if (pw_sum < LO_S) begin
      pw_cl = LO_S;
    end else if (pw_sum > HI_S) begin
      pw_cl = HI_S;
    end else begin
      pw_cl = pw_sum;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_T1;
        end
      end
      ST_T1:  state_nxt = ST_T2;
      ST_T2:  state_nxt = ST_T3;
      ST_T3:  state_nxt = ST_T4;
      ST_T4:  state_nxt = ST_MAP;
      ST_MAP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      cl_r        <= LIM_W'(1);
      mtp_r       <= '0;
      tp_r        <= '0;
      inv_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          REG_ACT_LIMIT:         cl_r  <= cfg_wdata[LIM_W-1:0];
          REG_MAX_TRIM_PERCENT:  mtp_r <= cfg_wdata[MTP_W-1:0];
          REG_TRIM_PERCENT:      tp_r  <= $signed(cfg_wdata[TP_W-1:0]);
          REG_INVERSE_DIRECTION: inv_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_fire) begin
        if (in_tuser[0]) begin
          acc_r <= '0;
        end else begin
          acc_r <= acc_r + in_tdata[ACT_W-1:0];
        end
      end

      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_T1: begin
        p_r <= P1_W'(HALF_SPAN * int'(mtp_eff));
        a_r <= inv_r ? -a_cl : a_cl;
      end
      ST_T2: begin
        tm_r <= tm2;
      end
      ST_T3: begin
        p_r <= P1_W'(prod3);
      end
      ST_T4: begin
        trim_r <= tp_r[TP_W-1] ? -$signed({1'b0, tm2}) : $signed({1'b0, tm2});
      end
      ST_MAP: begin
        dq_r   <= num;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(NUM_W - 1);
        base_r <= a_r[LIM_W+1] ? LO_S : (CENTER_S + trim_w);
      end
      ST_DIV: begin
        if (!rem_diff[LIM_W+1]) begin
          rem_r <= rem_diff[LIM_W:0];
          dq_r  <= {dq_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dq_r  <= {dq_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          out_pw_r  <= PW_OUT_W'(pw_cl);
          out_act_r <= acc_r;
        end
      end
      default: ;
    endcase
  end

endmodule
